// ===== src/macd_pkg.sv =====
// Shared types and constants for the MACD indicator engine.
// Used by macd_ema_unit and macd_indicator_engine; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package macd_pkg;

    // Storage defaults
    localparam int HISTORY_DEPTH_DEF = 256;

    // Field widths
    localparam int ALPHA_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = 48;
    localparam int DEA_W    = 49;
    localparam int HIST_W   = 51;
    localparam int SERIAL_W = 32;
    localparam int PRICE_W  = 32;
    localparam int OFFSET_W = 8;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 200;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ALPHA = 2'd2;

    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 16'd10082;
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 16'd4855;
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd13107;

    // Operation codes carried in the input tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Request to the shared EMA unit
    typedef struct packed {
        logic                      start;
        logic [ALPHA_W-1:0]        alpha;
        logic signed [DEA_W-1:0]   old_val;
        logic signed [DEA_W-1:0]   new_val;
    } t_ema_req;

    // Response from the shared EMA unit
    typedef struct packed {
        logic                      done;
        logic signed [DEA_W-1:0]   result;
    } t_ema_rsp;

endpackage

`default_nettype wire

// ===== src/macd_indicator_engine.sv =====
// MACD indicator engine top level: sequencer, averages, DEA history ring.
// Depends on macd_pkg and macd_ema_unit.
//
// Usage:
//   Input item on s_axis: tuser selects bar update or history query; tdata carries
//   bar serial, close price and history offset. Result item on m_axis: DIF, DEA,
//   histogram and the queried DEA, with tuser flagging a valid history read.
//   Weights are written through i_cfg_wr_en / i_cfg_index / i_cfg_data.
// Timing:
//   A regular bar update runs three EMA blends, fast, slow, then signal, through
//   one shared multiplier. A seeding update skips the blends; a query does one
//   registered history read. s_axis_tready is high only while the sequencer is
//   idle.
// Reset:
//   Synchronous, active low. Averages, counters and weights return to defaults;
//   the history ring is not cleared, only written entries are ever read.
// Stall:
//   The result sits in an output register; the block returns to idle and takes
//   the next item while it waits. A following result waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module macd_indicator_engine #(
    parameter int HISTORY_DEPTH = macd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [macd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [macd_pkg::ALPHA_W-1:0]      i_cfg_data,
    // Input items
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // bar_serial[31:0], close_price[63:32], history_offset[71:64]
    input  wire logic [macd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]                        s_axis_tuser,
    // Result items
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // dif_value[48:0], dea_value[97:49], histogram_value[148:98],
    // history_value[197:149], zero pad[199:198]
    output logic [macd_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // history_valid[0]
    output logic [0:0]                             m_axis_tuser
);

    localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > macd_pkg::OFFSET_W) ? CNT_W : macd_pkg::OFFSET_W;
    localparam int SLOT_W = ((HEAD_W > macd_pkg::OFFSET_W) ? HEAD_W : macd_pkg::OFFSET_W) + 1;
    localparam int AVG_W  = macd_pkg::AVG_W;
    localparam int DEA_W  = macd_pkg::DEA_W;
    localparam int PAD_W  = macd_pkg::M_TDATA_W - 3 * DEA_W - macd_pkg::HIST_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_EMA    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_QUERY  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [1:0] SEL_FAST = 2'd0;
    localparam logic [1:0] SEL_SLOW = 2'd1;
    localparam logic [1:0] SEL_SIG  = 2'd2;

    // Control and state registers
    logic [2:0]                   r_state;
    logic [1:0]                   r_ema_sel;
    logic                         r_start;
    logic [macd_pkg::ALPHA_W-1:0] r_fast_alpha;
    logic [macd_pkg::ALPHA_W-1:0] r_slow_alpha;
    logic [macd_pkg::ALPHA_W-1:0] r_signal_alpha;
    logic [AVG_W-1:0]             r_fast_avg;
    logic [AVG_W-1:0]             r_slow_avg;
    logic signed [DEA_W-1:0]      r_signal_avg;
    logic [AVG_W-1:0]             r_prior_fast;
    logic [AVG_W-1:0]             r_prior_slow;
    logic signed [DEA_W-1:0]      r_prior_signal;
    logic [macd_pkg::SERIAL_W-1:0] r_last_serial;
    logic [CNT_W-1:0]             r_bar_count;
    logic [HEAD_W-1:0]            r_head;
    logic                         r_m_valid;

    // Item payload registers
    logic                          r_op;
    logic [macd_pkg::SERIAL_W-1:0] r_serial;
    logic [macd_pkg::PRICE_W-1:0]  r_price;
    logic                          r_seed;
    logic                          r_revise;
    logic [HEAD_W-1:0]             r_slot;
    logic                          r_hvalid;
    logic signed [DEA_W-1:0]       r_rd_data;
    logic [macd_pkg::M_TDATA_W-1:0] r_m_data;
    logic [0:0]                    r_m_user;

    // History ring
    logic signed [DEA_W-1:0]       r_mem [HISTORY_DEPTH];

    // Combinational helpers
    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_in_op;
    logic [macd_pkg::SERIAL_W-1:0] w_in_serial;
    logic [macd_pkg::PRICE_W-1:0]  w_in_price;
    logic [macd_pkg::OFFSET_W-1:0] w_in_offset;
    logic                          w_in_revise;
    logic                          w_in_seed;
    logic                          w_hist_ok;
    logic [SLOT_W-1:0]             w_slot_raw;
    logic [SLOT_W-1:0]             w_slot_wrap;
    logic [HEAD_W-1:0]             w_slot;
    logic [AVG_W-1:0]              w_price_q;
    logic signed [DEA_W-1:0]       w_dif;
    logic signed [DEA_W:0]         w_dd;
    logic [macd_pkg::HIST_W-1:0]   w_hist;
    logic signed [DEA_W-1:0]       w_hval;
    macd_pkg::t_ema_req            w_req;
    macd_pkg::t_ema_rsp            w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Unpack the input item
    assign w_in_op     = s_axis_tuser[0];
    assign w_in_serial = s_axis_tdata[macd_pkg::SERIAL_W-1:0];
    assign w_in_price  = s_axis_tdata[macd_pkg::SERIAL_W +: macd_pkg::PRICE_W];
    assign w_in_offset = s_axis_tdata[macd_pkg::SERIAL_W + macd_pkg::PRICE_W +: macd_pkg::OFFSET_W];

    // Classify the update: revision of the newest bar, and seeding
    assign w_in_revise = (r_bar_count != '0) && (w_in_serial == r_last_serial);
    assign w_in_seed   = w_in_revise ? (r_bar_count == CNT_W'(1)) : (r_bar_count == '0);

    // Query range check and ring slot
    assign w_hist_ok   = CMP_W'(w_in_offset) < CMP_W'(r_bar_count);
    assign w_slot_raw  = SLOT_W'(r_head) - SLOT_W'(w_in_offset);
    assign w_slot_wrap = w_slot_raw + SLOT_W'(HISTORY_DEPTH);
    assign w_slot      = w_slot_raw[SLOT_W-1] ? w_slot_wrap[HEAD_W-1:0] : w_slot_raw[HEAD_W-1:0];

    // Price to Q32.16, DIF and histogram
    assign w_price_q = {r_price, {macd_pkg::FRAC_W{1'b0}}};
    assign w_dif     = $signed({1'b0, r_fast_avg}) - $signed({1'b0, r_slow_avg});
    assign w_dd      = (DEA_W+1)'(w_dif) - (DEA_W+1)'(r_signal_avg);
    assign w_hist    = {w_dd, 1'b0};
    assign w_hval    = r_hvalid ? r_rd_data : '0;

    // Operand selection for the shared EMA unit
    always_comb begin
        w_req.start = r_start;
        case (r_ema_sel)
            SEL_FAST: begin
                w_req.alpha   = r_fast_alpha;
                w_req.old_val = $signed({1'b0, r_prior_fast});
                w_req.new_val = $signed({1'b0, w_price_q});
            end
            SEL_SLOW: begin
                w_req.alpha   = r_slow_alpha;
                w_req.old_val = $signed({1'b0, r_prior_slow});
                w_req.new_val = $signed({1'b0, w_price_q});
            end
            default: begin
                w_req.alpha   = r_signal_alpha;
                w_req.old_val = r_prior_signal;
                w_req.new_val = w_dif;
            end
        endcase
    end

    macd_ema_unit u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_alpha   <= macd_pkg::FAST_ALPHA_RST;
            r_slow_alpha   <= macd_pkg::SLOW_ALPHA_RST;
            r_signal_alpha <= macd_pkg::SIGNAL_ALPHA_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                macd_pkg::REG_FAST_ALPHA:   r_fast_alpha   <= i_cfg_data;
                macd_pkg::REG_SLOW_ALPHA:   r_slow_alpha   <= i_cfg_data;
                macd_pkg::REG_SIGNAL_ALPHA: r_signal_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and indicator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ema_sel      <= SEL_FAST;
            r_start        <= 1'b0;
            r_fast_avg     <= '0;
            r_slow_avg     <= '0;
            r_signal_avg   <= '0;
            r_prior_fast   <= '0;
            r_prior_slow   <= '0;
            r_prior_signal <= '0;
            r_last_serial  <= '0;
            r_bar_count    <= '0;
            r_head         <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_start <= 1'b0;

            // Output register: load on finish, drop when taken
            if ((r_state == S_FINISH) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= (w_in_op == macd_pkg::OP_QUERY) ? S_QUERY : S_PREP;
                    end
                end
                S_QUERY: r_state <= S_FINISH;
                S_PREP: begin
                    // A new bar saves the averages and advances the ring
                    if (!r_revise) begin
                        r_prior_fast   <= r_fast_avg;
                        r_prior_slow   <= r_slow_avg;
                        r_prior_signal <= r_signal_avg;
                        if (r_bar_count != '0) begin
                            r_head <= (r_head == HEAD_W'(HISTORY_DEPTH - 1)) ?
                                      '0 : r_head + HEAD_W'(1);
                        end
                        if (r_bar_count < CNT_W'(HISTORY_DEPTH)) begin
                            r_bar_count <= r_bar_count + CNT_W'(1);
                        end
                    end
                    if (r_seed) begin
                        r_fast_avg   <= w_price_q;
                        r_slow_avg   <= w_price_q;
                        r_signal_avg <= '0;
                        r_state      <= S_WRITE;
                    end else begin
                        r_ema_sel <= SEL_FAST;
                        r_start   <= 1'b1;
                        r_state   <= S_EMA;
                    end
                end
                S_EMA: begin
                    // Chain fast, slow, then signal blends through the unit
                    if (w_rsp.done) begin
                        case (r_ema_sel)
                            SEL_FAST: begin
                                r_fast_avg <= w_rsp.result[AVG_W-1:0];
                                r_ema_sel  <= SEL_SLOW;
                                r_start    <= 1'b1;
                            end
                            SEL_SLOW: begin
                                r_slow_avg <= w_rsp.result[AVG_W-1:0];
                                r_ema_sel  <= SEL_SIG;
                                r_start    <= 1'b1;
                            end
                            default: begin
                                r_signal_avg <= w_rsp.result;
                                r_state      <= S_WRITE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    r_last_serial <= r_serial;
                    r_state       <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op     <= w_in_op;
            r_serial <= w_in_serial;
            r_price  <= w_in_price;
            r_revise <= w_in_revise;
            r_seed   <= w_in_seed;
            r_slot   <= w_slot;
            r_hvalid <= (w_in_op == macd_pkg::OP_QUERY) && w_hist_ok;
        end
    end

    // History ring: write the bar's DEA, read with registered data
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_head] <= r_signal_avg;
        end
        r_rd_data <= r_mem[r_slot];
    end

    // Build the result item
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && w_out_free) begin
            r_m_data    <= {{PAD_W{1'b0}}, w_hval, w_hist, r_signal_avg, w_dif};
            r_m_user[0] <= r_hvalid && (r_op == macd_pkg::OP_QUERY);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // Stored bar count never passes the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar_count <= CNT_W'(HISTORY_DEPTH))
        else $error("bar count beyond history depth");

    // A query leaves averages and ring position alone
    a_query_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_in_op == macd_pkg::OP_QUERY)) |=>
        ($stable(r_fast_avg) && $stable(r_slow_avg) && $stable(r_signal_avg) &&
         $stable(r_head) && $stable(r_bar_count)))
        else $error("query changed indicator state");

    // The ring head moves only while preparing an update
    a_head_in_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PREP) |=> $stable(r_head))
        else $error("history head moved outside update preparation");

    // The shared unit is started only inside the blend sequence
    a_start_in_ema: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_EMA))
        else $error("EMA start outside blend sequence");

endmodule

`default_nettype wire

// ===== src/macd_ema_unit.sv =====
// Shared EMA blend unit: result = old + floor((new - old) * alpha / 2^16).
// One 26x17 multiplier used twice per blend. Depends on macd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module macd_ema_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire macd_pkg::t_ema_req i_req,
    output macd_pkg::t_ema_rsp     o_rsp
);

    localparam int DIFF_W  = macd_pkg::DEA_W + 1;
    localparam int LO_W    = 25;
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int MUL_A_W = LO_W + 1;
    localparam int MUL_B_W = macd_pkg::ALPHA_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = macd_pkg::DEA_W + macd_pkg::FRAC_W;

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MLO  = 3'd1;
    localparam logic [2:0] U_MHI  = 3'd2;
    localparam logic [2:0] U_SUM  = 3'd3;
    localparam logic [2:0] U_OUT  = 3'd4;

    logic [2:0]                         r_state;
    logic                               r_done;
    logic signed [DIFF_W-1:0]           r_diff;
    logic signed [macd_pkg::DEA_W-1:0]  r_old;
    logic [macd_pkg::ALPHA_W-1:0]       r_alpha;
    logic signed [PROD_W-1:0]           r_prod;
    logic [ACC_W-1:0]                   r_acc;
    logic signed [macd_pkg::DEA_W-1:0]  r_res;

    logic signed [MUL_A_W-1:0]          w_mul_a;
    logic signed [MUL_B_W-1:0]          w_mul_b;
    logic signed [PROD_W-1:0]           w_prod;

    // Pick the low (unsigned) or high (signed) half of the difference
    always_comb begin
        if (r_state == U_MLO) begin
            w_mul_a = $signed({1'b0, r_diff[LO_W-1:0]});
        end else begin
            w_mul_a = $signed({r_diff[DIFF_W-1], r_diff[LO_W +: HI_W]});
        end
        w_mul_b = $signed({1'b0, r_alpha});
        w_prod  = w_mul_a * w_mul_b;
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_state <= U_MLO;
                    end
                end
                U_MLO: r_state <= U_MHI;
                U_MHI: r_state <= U_SUM;
                U_SUM: r_state <= U_OUT;
                U_OUT: begin
                    r_state <= U_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    // Datapath: latch operands, two partial products, combine, scale
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_diff  <= DIFF_W'(i_req.new_val) - DIFF_W'(i_req.old_val);
                    r_old   <= i_req.old_val;
                    r_alpha <= i_req.alpha;
                end
            end
            U_MLO: r_prod <= w_prod;
            U_MHI: begin
                r_acc  <= ACC_W'(r_prod);
                r_prod <= w_prod;
            end
            U_SUM: r_acc <= r_acc + {r_prod[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
            U_OUT: r_res <= r_old + $signed(r_acc[ACC_W-1:macd_pkg::FRAC_W]);
            default: ;
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    // A new blend starts only when the unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == U_IDLE))
        else $error("EMA unit started while busy");

    // Completion lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("EMA done held longer than one cycle");

    // Done follows the final step
    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == U_OUT) |=> r_done)
        else $error("EMA done missing after final step");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for macd_indicator_engine: bar updates, revisions and history
// queries are checked against a built-in MACD predictor. Depends on macd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CFG_IDX_W = macd_pkg::CFG_IDX_W;
    localparam int ALPHA_W   = macd_pkg::ALPHA_W;
    localparam int AVG_W     = macd_pkg::AVG_W;
    localparam int DEA_W     = macd_pkg::DEA_W;
    localparam int HIST_W    = macd_pkg::HIST_W;
    localparam int SERIAL_W  = macd_pkg::SERIAL_W;
    localparam int PRICE_W   = macd_pkg::PRICE_W;
    localparam int OFFSET_W  = macd_pkg::OFFSET_W;
    localparam int S_TDATA_W = macd_pkg::S_TDATA_W;
    localparam int M_TDATA_W = macd_pkg::M_TDATA_W;

    localparam int RING_DEPTH   = macd_pkg::HISTORY_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 120;
    localparam int PHASE_ITEMS  = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [DEA_W-1:0] DEA_OFFSET = 49'h1_0000_0000_0000;

    typedef struct packed {
        logic                op;
        logic [SERIAL_W-1:0] serial;
        logic [PRICE_W-1:0]  price;
        logic [OFFSET_W-1:0] offset;
    } t_bar_item;

    typedef struct packed {
        logic signed [DEA_W-1:0]  dif;
        logic signed [DEA_W-1:0]  dea;
        logic signed [HIST_W-1:0] hist;
        logic signed [DEA_W-1:0]  hval;
        logic                     hvalid;
    } t_macd_result;

    // DUT connections
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [ALPHA_W-1:0]      i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic [0:0]              m_axis_tuser;

    // Stimulus and expectation stores
    t_bar_item    pending_items[$];
    t_macd_result expected_results[$];
    t_bar_item    on_bus;
    int           items_queued = 0;
    int           items_accepted = 0;
    int           results_checked = 0;
    int           failures = 0;
    int           tx_idle_pct = 7;
    int           rx_idle_pct = 73;
    int           weight_settings = 0;

    // Predictor state
    logic [ALPHA_W-1:0]      fast_w = macd_pkg::FAST_ALPHA_RST;
    logic [ALPHA_W-1:0]      slow_w = macd_pkg::SLOW_ALPHA_RST;
    logic [ALPHA_W-1:0]      sig_w = macd_pkg::SIGNAL_ALPHA_RST;
    logic [AVG_W-1:0]        fast_ema = '0;
    logic [AVG_W-1:0]        slow_ema = '0;
    logic signed [DEA_W-1:0] dea_ema = '0;
    logic [AVG_W-1:0]        prev_fast = '0;
    logic [AVG_W-1:0]        prev_slow = '0;
    logic signed [DEA_W-1:0] prev_dea = '0;
    logic [SERIAL_W-1:0]     newest_serial = '0;
    int unsigned             bars_stored = 0;
    logic signed [DEA_W-1:0] dea_ring [0:RING_DEPTH-1];
    logic [OFFSET_W-1:0]     ring_head = '0;
    int                      n_updates = 0;
    int                      n_revisions = 0;
    int                      n_queries = 0;
    int                      n_valid_reads = 0;

    // Generator state, used only to shape the random sequences
    logic [SERIAL_W-1:0]     gen_serial = '0;
    logic [PRICE_W-1:0]      gen_price = 32'd100000;
    int                      gen_bars = 0;

    macd_indicator_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Exact floor((old * (1 - a) + new * a)) in Q0.16 weights
    function automatic logic [DEA_W-1:0] ema_mix(input logic [DEA_W-1:0] old_v,
                                                 input logic [DEA_W-1:0] new_v,
                                                 input logic [ALPHA_W-1:0] a);
        logic [16:0] keep_w;
        logic [79:0] acc;
        keep_w = 17'h10000 - {1'b0, a};
        acc = 80'(old_v) * 80'(keep_w) + 80'(new_v) * 80'(a);
        return acc[64:16];
    endfunction

    // Advance the MACD state by one item and return the result it produces
    function automatic t_macd_result predict_macd(input t_bar_item it);
        t_macd_result            r;
        logic [AVG_W-1:0]        price_q;
        logic                    revise;
        logic                    seed;
        logic [OFFSET_W-1:0]     slot;
        logic signed [DEA_W-1:0] dif_now;
        logic signed [HIST_W-1:0] dif_w;
        logic signed [HIST_W-1:0] dea_w;
        logic [DEA_W-1:0]        mixed;
        r = '0;
        price_q = {it.price, 16'h0000};
        if (it.op == macd_pkg::OP_UPDATE) begin
            n_updates++;
            revise = (bars_stored != 0) && (it.serial == newest_serial);
            if (revise) begin
                n_revisions++;
                seed = (bars_stored == 1);
            end else begin
                seed = (bars_stored == 0);
                prev_fast = fast_ema;
                prev_slow = slow_ema;
                prev_dea = dea_ema;
                if (bars_stored != 0)
                    ring_head = ring_head + 8'd1;
                if (bars_stored < RING_DEPTH)
                    bars_stored++;
            end
            if (seed) begin
                fast_ema = price_q;
                slow_ema = price_q;
                dea_ema = '0;
            end else begin
                fast_ema = AVG_W'(ema_mix({1'b0, prev_fast}, {1'b0, price_q}, fast_w));
                slow_ema = AVG_W'(ema_mix({1'b0, prev_slow}, {1'b0, price_q}, slow_w));
                dif_now = $signed({1'b0, fast_ema}) - $signed({1'b0, slow_ema});
                // Blend DEA in offset-binary so the unsigned blend stays exact
                mixed = ema_mix(prev_dea + DEA_OFFSET, dif_now + DEA_OFFSET, sig_w);
                dea_ema = mixed - DEA_OFFSET;
            end
            newest_serial = it.serial;
            dea_ring[ring_head] = dea_ema;
        end else begin
            n_queries++;
            if (it.offset < bars_stored) begin
                slot = ring_head - it.offset;
                r.hval = dea_ring[slot];
                r.hvalid = 1'b1;
                n_valid_reads++;
            end
        end
        dif_now = $signed({1'b0, fast_ema}) - $signed({1'b0, slow_ema});
        dif_w = dif_now;
        dea_w = dea_ema;
        r.dif = dif_now;
        r.dea = dea_ema;
        r.hist = (dif_w - dea_w) <<< 1;
        return r;
    endfunction

    function void note_failure(input string msg);
        failures++;
        $display("%0t ns: %s", $time, msg);
    endfunction

    function void add_update(input logic [SERIAL_W-1:0] serial,
                             input logic [PRICE_W-1:0] price);
        t_bar_item it;
        it.op = macd_pkg::OP_UPDATE;
        it.serial = serial;
        it.price = price;
        it.offset = OFFSET_W'($urandom);
        if (gen_bars == 0 || serial != gen_serial)
            gen_bars++;
        gen_serial = serial;
        gen_price = price;
        pending_items = {pending_items, it};
        items_queued++;
    endfunction

    function void add_query(input logic [OFFSET_W-1:0] offset);
        t_bar_item it;
        it.op = macd_pkg::OP_QUERY;
        it.serial = $urandom;
        it.price = $urandom;
        it.offset = offset;
        pending_items = {pending_items, it};
        items_queued++;
    endfunction

    // History queries and mostly consecutive bars with revisions, a few jumps and extreme prices
    function void add_random_items(input int count);
        int pick;
        int span;
        logic [SERIAL_W-1:0] serial;
        logic [PRICE_W-1:0]  price;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
                span = (gen_bars > RING_DEPTH) ? RING_DEPTH : gen_bars;
                if (span != 0 && $urandom_range(9, 0) < 8)
                    add_query(OFFSET_W'($urandom_range(span - 1, 0)));
                else
                    add_query(OFFSET_W'($urandom));
            end else begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    serial = gen_serial + 32'd1;
                else if (pick < 85)
                    serial = gen_serial;
                else if (pick < 95)
                    serial = $urandom;
                else
                    serial = gen_serial - 32'd1;
                pick = $urandom_range(99, 0);
                if (pick < 65)
                    price = gen_price + 32'($urandom_range(2000, 0)) - 32'd1000;
                else if (pick < 85)
                    price = $urandom;
                else if (pick < 92)
                    price = '0;
                else
                    price = '1;
                add_update(serial, price);
            end
        end
    endfunction

    // Feed queued items onto the input stream; predict each one as it is accepted
    always @(posedge i_clk) begin : item_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results = {expected_results, predict_macd(on_bus)};
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    on_bus = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {on_bus.offset, on_bus.price, on_bus.serial};
                    s_axis_tuser <= on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each result item against the oldest expectation; drive backpressure
    always @(posedge i_clk) begin : result_monitor
        t_macd_result got;
        t_macd_result want;
        int           hold_left;
        bit           long_hold_done;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.dif = m_axis_tdata[48:0];
                got.dea = m_axis_tdata[97:49];
                got.hist = m_axis_tdata[148:98];
                got.hval = m_axis_tdata[197:149];
                got.hvalid = m_axis_tuser[0];
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result item, actual %h", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.dif !== want.dif)
                        note_failure($sformatf("DIF expected %h actual %h",
                                               want.dif, got.dif));
                    if (got.dea !== want.dea)
                        note_failure($sformatf("DEA expected %h actual %h",
                                               want.dea, got.dea));
                    if (got.hist !== want.hist)
                        note_failure($sformatf("histogram expected %h actual %h",
                                               want.hist, got.hist));
                    if (got.hval !== want.hval)
                        note_failure($sformatf("history value expected %h actual %h",
                                               want.hval, got.hval));
                    if (got.hvalid !== want.hvalid)
                        note_failure($sformatf("history valid expected %h actual %h",
                                               want.hvalid, got.hvalid));
                end
                results_checked++;
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (!long_hold_done && results_checked == HOLD_AT) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    // End the run when nothing moves on either stream for too long
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // Wait until every queued item is accepted and every result has come back
    task automatic drain();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ALPHA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            macd_pkg::REG_FAST_ALPHA:   fast_w = val;
            macd_pkg::REG_SLOW_ALPHA:   slow_w = val;
            macd_pkg::REG_SIGNAL_ALPHA: sig_w = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Set all three weights while idle, then run a batch of random items
    task automatic run_phase(input logic [ALPHA_W-1:0] fast_a,
                             input logic [ALPHA_W-1:0] slow_a,
                             input logic [ALPHA_W-1:0] sig_a);
        write_weight(macd_pkg::REG_FAST_ALPHA, fast_a);
        write_weight(macd_pkg::REG_SLOW_ALPHA, slow_a);
        write_weight(macd_pkg::REG_SIGNAL_ALPHA, sig_a);
        weight_settings++;
        @(negedge i_clk);
        add_random_items(PHASE_ITEMS);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty history, first bar, revisions, extreme serials and prices
        add_query(8'd0);
        add_query(8'hFF);
        add_update(32'd0, 32'd1000);
        add_update(32'd0, 32'd2000);
        add_query(8'd0);
        add_query(8'd1);
        add_update(32'd1, 32'hFFFF_FFFF);
        add_update(32'd1, 32'd0);
        add_update(32'd2, 32'd0);
        add_update(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_update(32'd0, 32'd12345);
        add_update(32'd0, 32'hFFFF_FFFF);
        add_update(32'h8000_0000, 32'h5555_5555);
        add_update(32'h7FFF_FFFF, 32'hAAAA_AAAA);
        for (int k = 0; k < 8; k++)
            add_query(OFFSET_W'(k));
        add_query(8'hFF);
        drain();

        // Fast sender, busy receiver
        run_phase(macd_pkg::FAST_ALPHA_RST, macd_pkg::SLOW_ALPHA_RST,
                  macd_pkg::SIGNAL_ALPHA_RST);
        run_phase(16'd0, 16'd0, 16'd0);

        // Slow sender, fast receiver
        tx_idle_pct = 73;
        rx_idle_pct = 7;
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(ALPHA_W'($urandom), ALPHA_W'($urandom), ALPHA_W'($urandom));

        // Full rate both sides; a write to the unused index must change nothing
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_weight(REG_UNUSED, ALPHA_W'($urandom));
        run_phase(16'hFFFF, 16'd0, 16'd1);
        run_phase(macd_pkg::FAST_ALPHA_RST, macd_pkg::SLOW_ALPHA_RST,
                  macd_pkg::SIGNAL_ALPHA_RST);

        $display("Ran %0d bar updates (%0d revisions) and %0d history queries (%0d valid reads)",
                 n_updates, n_revisions, n_queries, n_valid_reads);
        $display("over %0d weight settings; %0d results checked, %0d mismatches",
                 weight_settings, results_checked, failures);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
